/* hdl/ssk_pkg.sv */
// ----------------------------------------------------------------------------
// ssk_pkg
// Shared constants, register indexes and types for the Stirling number table.
// ----------------------------------------------------------------------------
package ssk_pkg;

  localparam int MAX_N_DEF   = 64;
  localparam int VALUE_W     = 64;
  localparam int MOD_W       = 31;
  localparam int CFG_W       = 31;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 2'd2;

  typedef struct packed {
    logic lookup;
    logic status;
  } ssk_cls_t;

endpackage

/* hdl/stirling_second_kind_table.sv */
// Order: an out-of-range or k>n query is answered without a table read, a look-up in
// built rows reads the memory in S_LOOK and S_LWAIT. Row 0 is written in S_ROW0, every
// later row per column by S_RD, S_WAIT, the shift-and-subtract reduction loop in S_RED
// (nonzero modulus only) and S_WR, paced by the single memory port pair.
// Rate: one immediate answer per cycle while idle and not stalled; look-ups never overlap.
// Reset: asynchronous, clears the built-row count; the table memory is not cleared.
// ----------------------------------------------------------------------------
// stirling_second_kind_table
// Top level: configuration registers, query classifier, queue and table engine.
// ----------------------------------------------------------------------------
module stirling_second_kind_table #(
  parameter int MAX_N = ssk_pkg::MAX_N_DEF,
  localparam int NW = $clog2(MAX_N + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ssk_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ssk_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          query_valid_i,
  output logic                          query_ready_o,
  input  logic [NW-1:0]                 query_n_i,
  input  logic [NW-1:0]                 query_k_i,
  output logic                          result_valid_o,
  input  logic                          result_ready_i,
  output logic [ssk_pkg::VALUE_W-1:0]   value_o,
  output logic                          status_o
);
  import ssk_pkg::*;

  localparam int QW = $bits(ssk_cls_t) + 2 * NW;

  logic [NW-1:0]    table_rows_q;
  logic [NW-1:0]    table_cols_q;
  logic [MOD_W-1:0] modulus_q;
  logic [NW-1:0]    eff_rows;
  logic [NW-1:0]    eff_cols;
  logic             cfg_clear;

  logic             push_valid, push_ready;
  ssk_cls_t         push_cls;
  logic [NW-1:0]    push_n, push_k;
  logic             pop_valid, pop_ready;
  logic [QW-1:0]    pop_data;
  ssk_cls_t         pop_cls;
  logic [NW-1:0]    pop_n, pop_k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_rows_q <= NW'(MAX_N);
      table_cols_q <= NW'(MAX_N);
      modulus_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TABLE_ROWS: table_rows_q <= cfg_wdata_i[NW-1:0];
        CFG_TABLE_COLS: table_cols_q <= cfg_wdata_i[NW-1:0];
        CFG_MODULUS:    modulus_q    <= cfg_wdata_i[MOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_clear = cfg_we_i && ((cfg_idx_i == CFG_TABLE_ROWS) ||
                                  (cfg_idx_i == CFG_TABLE_COLS) ||
                                  (cfg_idx_i == CFG_MODULUS));
  assign eff_rows  = (table_rows_q > NW'(MAX_N)) ? NW'(MAX_N) : table_rows_q;
  assign eff_cols  = (table_cols_q > eff_rows) ? eff_rows : table_cols_q;

  ssk_front #(
    .NW(NW)
  ) u_front (
    .query_valid_i(query_valid_i),
    .query_ready_o(query_ready_o),
    .query_n_i    (query_n_i),
    .query_k_i    (query_k_i),
    .eff_rows_i   (eff_rows),
    .eff_cols_i   (eff_cols),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_cls_o   (push_cls),
    .push_n_o     (push_n),
    .push_k_o     (push_k)
  );

  ssk_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i ({push_cls, push_n, push_k}),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  assign {pop_cls, pop_n, pop_k} = pop_data;

  ssk_back #(
    .MAX_N(MAX_N)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (pop_valid),
    .cmd_ready_o   (pop_ready),
    .cmd_cls_i     (pop_cls),
    .cmd_n_i       (pop_n),
    .cmd_k_i       (pop_k),
    .eff_cols_i    (eff_cols),
    .modulus_i     (modulus_q),
    .clear_i       (cfg_clear),
    .result_valid_o(result_valid_o),
    .result_ready_i(result_ready_i),
    .value_o       (value_o),
    .status_o      (status_o)
  );

endmodule

/* hdl/ssk_ram.sv */
// ----------------------------------------------------------------------------
// ssk_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ssk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4225,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/ssk_front.sv */
// ----------------------------------------------------------------------------
// ssk_front
// Accepts queries and sorts them into table look-ups and immediate answers.
// ----------------------------------------------------------------------------
module ssk_front #(
  parameter int NW = 7
) (
  input  logic              query_valid_i,
  output logic              query_ready_o,
  input  logic [NW-1:0]     query_n_i,
  input  logic [NW-1:0]     query_k_i,
  input  logic [NW-1:0]     eff_rows_i,
  input  logic [NW-1:0]     eff_cols_i,
  input  logic              push_ready_i,
  output logic              push_valid_o,
  output ssk_pkg::ssk_cls_t push_cls_o,
  output logic [NW-1:0]     push_n_o,
  output logic [NW-1:0]     push_k_o
);
  import ssk_pkg::*;

  // The row limit is checked before anything else; k above n is a plain zero.
  always_comb begin
    push_cls_o = '0;
    priority if (query_n_i > eff_rows_i) begin
      push_cls_o.status = 1'b1;
    end else if (query_k_i > query_n_i) begin
      push_cls_o.status = 1'b0;
    end else if (query_k_i > eff_cols_i) begin
      push_cls_o.status = 1'b1;
    end else begin
      push_cls_o.lookup = 1'b1;
    end
  end

  assign push_valid_o  = query_valid_i;
  assign query_ready_o = push_ready_i;
  assign push_n_o      = query_n_i;
  assign push_k_o      = query_k_i;

endmodule

/* hdl/ssk_queue.sv */
// ----------------------------------------------------------------------------
// ssk_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module ssk_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/ssk_back.sv */
// ----------------------------------------------------------------------------
// ssk_back
// Builds table rows on demand with the recurrence, reduces each computed entry by a
// nonzero modulus with a shift-and-subtract unit, and reads look-up answers from memory.
// ----------------------------------------------------------------------------
module ssk_back #(
  parameter int MAX_N = 64,
  localparam int NW = $clog2(MAX_N + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  ssk_pkg::ssk_cls_t           cmd_cls_i,
  input  logic [NW-1:0]               cmd_n_i,
  input  logic [NW-1:0]               cmd_k_i,
  input  logic [NW-1:0]               eff_cols_i,
  input  logic [ssk_pkg::MOD_W-1:0]   modulus_i,
  input  logic                        clear_i,
  output logic                        result_valid_o,
  input  logic                        result_ready_i,
  output logic [ssk_pkg::VALUE_W-1:0] value_o,
  output logic                        status_o
);
  import ssk_pkg::*;

  localparam int DIM   = MAX_N + 1;
  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int RBW   = $clog2(MAX_N + 2);
  localparam int SW    = (NW > 1) ? $clog2(NW) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROW0  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_RED   = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;
  localparam logic [2:0] S_LOOK  = 3'd6;
  localparam logic [2:0] S_LWAIT = 3'd7;

  logic [2:0]         state_q, state_d;
  logic [RBW-1:0]     rows_q, rows_d;
  logic [NW-1:0]      n_q, n_d;
  logic [NW-1:0]      k_q, k_d;
  logic [NW-1:0]      col_q, col_d;
  logic [SW-1:0]      step_q, step_d;
  logic [VALUE_W-1:0] left_q, left_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic               status_q, status_d;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic [NW-1:0]      cur_row;
  logic [NW-1:0]      prev_row;
  logic [VALUE_W-1:0] sub;
  logic [VALUE_W-1:0] one_red;
  logic               out_free;
  logic               row_end;

  function automatic logic [AW-1:0] entry_addr(logic [NW-1:0] row, logic [NW-1:0] col);
    return AW'(AW'(row) * AW'(DIM) + AW'(col));
  endfunction

  assign cur_row  = rows_q[NW-1:0];
  assign prev_row = cur_row - 1'b1;
  assign sub      = VALUE_W'(modulus_i) << step_q;
  assign one_red  = (modulus_i == MOD_W'(1)) ? '0 : VALUE_W'(1);
  assign out_free = !out_valid_q || result_ready_i;

  assign cmd_ready_o    = (state_q == S_IDLE) && out_free;
  assign result_valid_o = out_valid_q;
  assign value_o        = value_q;
  assign status_o       = status_q;

  always_comb begin
    state_d     = state_q;
    rows_d      = rows_q;
    n_d         = n_q;
    k_d         = k_q;
    col_d       = col_q;
    step_d      = step_q;
    left_d      = left_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    value_d     = value_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = '0;
    row_end     = 1'b0;

    if (out_valid_q && result_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          n_d = cmd_n_i;
          k_d = cmd_k_i;
          col_d = '0;
          if (!cmd_cls_i.lookup) begin
            out_valid_d = 1'b1;
            value_d     = '0;
            status_d    = cmd_cls_i.status;
          end else if (RBW'(cmd_n_i) < rows_q) begin
            state_d = S_LOOK;
          end else if (rows_q == '0) begin
            state_d = S_ROW0;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_ROW0: begin
        ram_we    = 1'b1;
        ram_waddr = entry_addr('0, col_q);
        ram_wdata = (col_q == '0) ? one_red : '0;
        if (col_q == eff_cols_i) begin
          row_end = 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      S_RD: begin
        ram_raddr = entry_addr(prev_row, col_q);
        if (col_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = entry_addr(cur_row, '0);
          ram_wdata = '0;
        end
        state_d = S_WAIT;
      end
      S_WAIT: begin
        left_d = ram_rdata;
        if (col_q == '0) begin
          if (eff_cols_i == '0) begin
            row_end = 1'b1;
          end else begin
            col_d   = NW'(1);
            state_d = S_RD;
          end
        end else begin
          acc_d   = left_q + ram_rdata * VALUE_W'(col_q);
          step_d  = SW'(NW - 1);
          state_d = (modulus_i != '0) ? S_RED : S_WR;
        end
      end
      S_RED: begin
        if (acc_q >= sub) begin
          acc_d = acc_q - sub;
        end
        if (step_q == '0) begin
          state_d = S_WR;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = entry_addr(cur_row, col_q);
        ram_wdata = acc_q;
        if (col_q == eff_cols_i) begin
          row_end = 1'b1;
        end else begin
          col_d   = col_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_LOOK: begin
        ram_raddr = entry_addr(n_q, k_q);
        state_d   = S_LWAIT;
      end
      S_LWAIT: begin
        out_valid_d = 1'b1;
        value_d     = ram_rdata;
        status_d    = 1'b0;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (row_end) begin
      rows_d = rows_q + 1'b1;
      col_d  = '0;
      if (cur_row == n_q) begin
        state_d = S_LOOK;
      end else begin
        state_d = S_RD;
      end
    end

    if (clear_i) begin
      rows_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rows_q      <= '0;
      col_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rows_q      <= rows_d;
      col_q       <= col_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    k_q      <= k_d;
    left_q   <= left_d;
    acc_q    <= acc_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  ssk_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule

/* hdl/ssk_checker.sv */
// ----------------------------------------------------------------------------
// ssk_checker
// Port-level checks on the Stirling number table, bound to the top level.
// ----------------------------------------------------------------------------
module ssk_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        query_valid_i,
  input logic                        query_ready_o,
  input logic                        result_valid_o,
  input logic                        result_ready_i,
  input logic [ssk_pkg::VALUE_W-1:0] value_o,
  input logic                        status_o
);
  import ssk_pkg::*;

  localparam logic [3:0] MAX_PEND = 4'(QUEUE_DEPTH + 2);

  logic [3:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = query_valid_i && query_ready_o;
  assign out_acc = result_valid_o && result_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=>
      result_valid_o && $stable(value_o) && $stable(status_o))
    else $error("Result changed while stalled.");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o |-> value_o == '0)
    else $error("Error result carries a nonzero value.");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> pend_q != '0)
    else $error("Result offered with no item outstanding.");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= MAX_PEND)
    else $error("More items outstanding than the block can hold.");

endmodule

bind stirling_second_kind_table ssk_checker u_ssk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .query_valid_i (query_valid_i),
  .query_ready_o (query_ready_o),
  .result_valid_o(result_valid_o),
  .result_ready_i(result_ready_i),
  .value_o       (value_o),
  .status_o      (status_o)
);
